[rtl/modexp_pkg.sv]
`timescale 1ns / 1ps

package modexp_pkg;

  localparam int unsigned RES_W = 30;
  localparam int unsigned MUL_W = 32;

  typedef logic [RES_W-1:0]   residue_t;
  typedef logic [MUL_W-1:0]   mul_op_t;
  typedef logic [2*MUL_W-1:0] mul_prod_t;

  localparam residue_t PRIME_MOD = 30'd998244353;
  localparam residue_t RES_ONE   = 30'd1;

  // Barrett constant floor(2^60 / P); P lies in [2^29, 2^30)
  localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'(PRIME_MOD));

  localparam mul_op_t PRIME_X1 = {2'b00, PRIME_MOD};
  localparam mul_op_t PRIME_X2 = {1'b0, PRIME_MOD, 1'b0};

endpackage

[rtl/modular_exponentiation.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall   base_value[29:0], exponent_value[EXP_BITS-1:0]
// out       output     out_valid / out_stall power_result[29:0]
//
// One modular multiply steps through the single 32x32 multiplier in order: product,
// Barrett quotient estimate, quotient times P, then subtract and correct.
// Reset is synchronous and clears the sequencer and out_valid. in_stall is high
// from accept until the result is loaded into the output register.
module modular_exponentiation
  import modexp_pkg::*;
#(
  parameter int unsigned EXP_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [29:0]         base_value,
  input  logic [EXP_BITS-1:0] exponent_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [29:0]         power_result
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_EST  = 3'd2;
  localparam logic [2:0] ST_QM   = 3'd3;
  localparam logic [2:0] ST_FIX  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]          state;
  logic                op_sq;   // 1: square the running power, 0: fold it into acc
  residue_t            acc;
  residue_t            sq;
  logic [EXP_BITS-1:0] expo;
  mul_prod_t           mul_q;
  mul_op_t             plow;

  mul_op_t             mul_a;
  mul_op_t             mul_b;
  mul_prod_t           mul_out;
  residue_t            base_red;
  logic [EXP_BITS-1:0] expo_shr;
  mul_op_t             rem;
  mul_op_t             rem_m1;
  mul_op_t             rem_m2;
  residue_t            fix_val;

  assign in_stall = (state != ST_IDLE);

  assign base_red = (base_value >= PRIME_MOD) ? base_value - PRIME_MOD : base_value;
  assign expo_shr = expo >> 1;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MUL: begin
        mul_a = {2'b00, (op_sq ? sq : acc)};
        mul_b = {2'b00, sq};
      end
      ST_EST: begin
        mul_a = {1'b0, mul_q[59:29]};
        mul_b = {1'b0, BARRETT_MU};
      end
      ST_QM: begin
        mul_a = {1'b0, mul_q[61:31]};
        mul_b = PRIME_X1;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_out = mul_a * mul_b;

  // remainder lies in [0, 3P), at most two subtractions of P
  assign rem    = plow - mul_q[MUL_W-1:0];
  assign rem_m1 = rem - PRIME_X1;
  assign rem_m2 = rem - PRIME_X2;

  always_comb begin
    if (rem >= PRIME_X2) begin
      fix_val = rem_m2[RES_W-1:0];
    end else if (rem >= PRIME_X1) begin
      fix_val = rem_m1[RES_W-1:0];
    end else begin
      fix_val = rem[RES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op_sq     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // in ST_DONE the load below owns out_valid
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            sq   <= base_red;
            acc  <= RES_ONE;
            expo <= exponent_value;
            if (exponent_value == '0) begin
              state <= ST_DONE;
            end else begin
              op_sq <= !exponent_value[0];
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          mul_q <= mul_out;
          state <= ST_EST;
        end
        ST_EST: begin
          mul_q <= mul_out;
          plow  <= mul_q[MUL_W-1:0];
          state <= ST_QM;
        end
        ST_QM: begin
          mul_q <= mul_out;
          state <= ST_FIX;
        end
        ST_FIX: begin
          if (op_sq) begin
            sq   <= fix_val;
            expo <= expo_shr;
            if (expo_shr == '0) begin
              state <= ST_DONE;
            end else begin
              op_sq <= !expo_shr[0];
              state <= ST_MUL;
            end
          end else begin
            acc <= fix_val;
            // no square needed once the top set bit is consumed
            if (expo_shr == '0) begin
              state <= ST_DONE;
            end else begin
              op_sq <= 1'b1;
              state <= ST_MUL;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            power_result <= acc;
            out_valid    <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
